// ----- sv/pba_pkg.sv -----
// Shared types, constants and register indexes of the proximity beep alarm.
package pba_pkg;

	// Field widths.
	localparam int unsigned ECHO_W      = 15;
	localparam int unsigned DIST_W      = 13;
	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned SUM_W       = 16;
	localparam int unsigned SIDX_W      = 3;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// Shared multiplier operand and product widths.
	localparam int unsigned MUL_A_W = 18;
	localparam int unsigned MUL_B_W = 19;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// Echo to distance: floor(echo*8/29) as (echo*8*RECIP_29) >> RECIP_SHIFT.
	// The reciprocal is rounded up; the error stays below one part in 29 for
	// every 15-bit echo, so the quotient is exact.
	localparam logic [MUL_B_W-1:0] RECIP_29    = 19'd289263;
	localparam int unsigned        RECIP_SHIFT = 23;
	localparam int unsigned        SDIST_W     = DIST_W + 1;

	// Shared divider widths.
	localparam int unsigned DIV_NUM_W = 30;
	localparam int unsigned DIV_DEN_W = 13;
	localparam int unsigned DIV_CNT_W = 5;

	// Item kinds.
	localparam logic CMD_ECHO = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_ALARM_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NEAR_DISTANCE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALID       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALID       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD     = 3'd5;

	// Register values after reset.
	localparam logic [DIST_W-1:0]   THRESHOLD_RST = 13'd320;
	localparam logic [DIST_W-1:0]   NEAR_RST      = 13'd80;
	localparam logic [DIST_W-1:0]   MIN_VALID_RST = 13'd32;
	localparam logic [DIST_W-1:0]   MAX_VALID_RST = 13'd6400;
	localparam logic [PERIOD_W-1:0] SLOW_RST      = 16'd600;
	localparam logic [PERIOD_W-1:0] FAST_RST      = 16'd120;

	// Input item.
	typedef struct packed {
		logic              cmd;
		logic [ECHO_W-1:0] echo_us;
	} req_t;

	// Result item.
	typedef struct packed {
		logic              buzzer_on;
		logic [DIST_W-1:0] distance;
		logic              distance_valid;
		logic              alarm_active;
		logic              measure_done;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept_tick;
		logic accept_echo;
		logic acc_sample;
		logic end_meas;
		logic div_avg;
		logic store_avg;
		logic buzz_off;
		logic load_fast;
		logic mul_interval;
		logic div_interval;
		logic load_interp;
		logic buzz_update;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic meas_end;
		logic any_valid;
		logic div_busy;
		logic dist_silent;
		logic dist_near;
		logic out_busy;
	} status_t;

endpackage

// ----- sv/pba_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pba_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pba_pkg::DIV_NUM_W-1:0]  numer,
	input  logic [pba_pkg::DIV_DEN_W-1:0]  denom,
	output logic                           busy,
	output logic [pba_pkg::DIV_NUM_W-1:0]  quot
);

	logic                          busy_q;
	logic [pba_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pba_pkg::DIV_NUM_W-1:0] work_q;
	logic [pba_pkg::DIV_DEN_W-1:0] rem_q;
	logic [pba_pkg::DIV_DEN_W-1:0] den_q;
	logic [pba_pkg::DIV_DEN_W:0]   trial;
	logic                          fits;

	// Trial subtraction of the shifted remainder.
	assign trial = {rem_q, work_q[pba_pkg::DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control: busy until every quotient bit has been formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pba_pkg::DIV_CNT_W'(pba_pkg::DIV_NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend shifts out at the top as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= numer;
			rem_q  <= '0;
			den_q  <= denom;
		end else if (busy_q) begin
			work_q <= {work_q[pba_pkg::DIV_NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= pba_pkg::DIV_DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[pba_pkg::DIV_DEN_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign quot = work_q;

endmodule

// ----- sv/pba_datapath.sv -----
// Datapath of the proximity beep alarm: registers, multiplier, divider, result register.
module pba_datapath #(
	parameter int unsigned SAMPLES_PER_MEASURE = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pba_pkg::cmd_t                     cmd,
	output pba_pkg::status_t                  status,
	input  logic [pba_pkg::ECHO_W-1:0]        echo_us,
	input  logic                              cfg_valid,
	input  logic [pba_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pba_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              rsp_stall,
	output logic                              rsp_valid,
	output pba_pkg::rsp_t                     rsp
);

	// Configuration registers.
	logic [pba_pkg::DIST_W-1:0]   thr_q, near_q, min_q, max_q;
	logic [pba_pkg::PERIOD_W-1:0] slow_q, fast_q;

	// Measurement and buzzer state.
	logic [pba_pkg::TIME_W-1:0]   time_q, last_toggle_q;
	logic                         toggle_q, buzzer_q;
	logic [pba_pkg::SIDX_W-1:0]   sample_idx_q, valid_cnt_q;
	logic [pba_pkg::SUM_W-1:0]    sum_q;
	logic [pba_pkg::DIST_W-1:0]   last_dist_q;
	logic                         last_valid_q, done_q;
	logic                         echo_nz_q;
	logic [pba_pkg::PERIOD_W-1:0] interval_q;
	logic [pba_pkg::MUL_P_W-1:0]  prod_s1;
	pba_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	logic [pba_pkg::MUL_A_W-1:0]   mul_a;
	logic [pba_pkg::MUL_B_W-1:0]   mul_b;
	logic [pba_pkg::MUL_P_W-1:0]   mul_p;
	logic [pba_pkg::SDIST_W-1:0]   samp_dist;
	logic                          in_range;
	logic                          slow_ge_fast;
	logic [pba_pkg::PERIOD_W-1:0]  per_diff;
	logic [pba_pkg::DIST_W-1:0]    den_int;
	logic [pba_pkg::DIV_NUM_W-1:0] ceil_adj;
	logic                          div_start;
	logic [pba_pkg::DIV_NUM_W-1:0] div_numer;
	logic [pba_pkg::DIV_DEN_W-1:0] div_denom;
	logic                          div_busy;
	logic [pba_pkg::DIV_NUM_W-1:0] div_quot;
	logic [pba_pkg::TIME_W-1:0]    elapsed;
	logic                          alarm;

	// Configuration writes, masked to the register widths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= pba_pkg::THRESHOLD_RST;
			near_q <= pba_pkg::NEAR_RST;
			min_q  <= pba_pkg::MIN_VALID_RST;
			max_q  <= pba_pkg::MAX_VALID_RST;
			slow_q <= pba_pkg::SLOW_RST;
			fast_q <= pba_pkg::FAST_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pba_pkg::REG_ALARM_THRESHOLD: thr_q  <= cfg_data[pba_pkg::DIST_W-1:0];
				pba_pkg::REG_NEAR_DISTANCE:   near_q <= cfg_data[pba_pkg::DIST_W-1:0];
				pba_pkg::REG_MIN_VALID:       min_q  <= cfg_data[pba_pkg::DIST_W-1:0];
				pba_pkg::REG_MAX_VALID:       max_q  <= cfg_data[pba_pkg::DIST_W-1:0];
				pba_pkg::REG_SLOW_PERIOD:     slow_q <= cfg_data;
				pba_pkg::REG_FAST_PERIOD:     fast_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Interpolation terms.
	assign slow_ge_fast = slow_q >= fast_q;
	assign per_diff     = slow_ge_fast ? slow_q - fast_q : fast_q - slow_q;
	assign den_int      = thr_q - near_q;
	assign ceil_adj     = slow_ge_fast ? '0
		: pba_pkg::DIV_NUM_W'(den_int) - pba_pkg::DIV_NUM_W'(1);

	// Shared multiplier: echo by the reciprocal of 29, or distance offset by period span.
	always_comb begin
		if (cmd.mul_interval) begin
			mul_a = pba_pkg::MUL_A_W'(last_dist_q - near_q);
			mul_b = pba_pkg::MUL_B_W'(per_diff);
		end else begin
			mul_a = {echo_us, 3'b000};
			mul_b = pba_pkg::RECIP_29;
		end
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.accept_echo || cmd.mul_interval) begin
			prod_s1 <= mul_p;
		end
	end

	// Sample distance and its acceptance window.
	assign samp_dist = prod_s1[pba_pkg::RECIP_SHIFT +: pba_pkg::SDIST_W];
	assign in_range  = echo_nz_q && (samp_dist >= {1'b0, min_q})
		&& (samp_dist <= {1'b0, max_q});

	// Shared divider: average of the samples, or the interval step.
	assign div_start = cmd.div_avg || cmd.div_interval;
	assign div_numer = cmd.div_avg ? pba_pkg::DIV_NUM_W'(sum_q)
		: pba_pkg::DIV_NUM_W'(prod_s1[pba_pkg::DIV_NUM_W-2:0]) + ceil_adj;
	assign div_denom = cmd.div_avg ? pba_pkg::DIV_DEN_W'(valid_cnt_q) : den_int;

	pba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign elapsed = time_q - last_toggle_q;

	// Sample accumulation and measurement state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			last_toggle_q <= '0;
			toggle_q      <= 1'b0;
			buzzer_q      <= 1'b0;
			sample_idx_q  <= '0;
			valid_cnt_q   <= '0;
			sum_q         <= '0;
			last_dist_q   <= '0;
			last_valid_q  <= 1'b0;
			done_q        <= 1'b0;
			echo_nz_q     <= 1'b0;
		end else begin
			if (cmd.accept_tick || cmd.accept_echo) begin
				done_q <= 1'b0;
			end
			if (cmd.accept_tick) begin
				time_q <= time_q + 1'b1;
			end
			if (cmd.accept_echo) begin
				echo_nz_q <= echo_us != '0;
			end
			if (cmd.acc_sample) begin
				sample_idx_q <= sample_idx_q + 1'b1;
				if (in_range) begin
					sum_q       <= sum_q + pba_pkg::SUM_W'(samp_dist);
					valid_cnt_q <= valid_cnt_q + 1'b1;
				end
			end
			if (cmd.end_meas) begin
				sample_idx_q <= '0;
				valid_cnt_q  <= '0;
				sum_q        <= '0;
				done_q       <= 1'b1;
				if (valid_cnt_q == '0) begin
					last_dist_q  <= '0;
					last_valid_q <= 1'b0;
				end
			end
			if (cmd.store_avg) begin
				last_dist_q  <= div_quot[pba_pkg::DIST_W-1:0];
				last_valid_q <= 1'b1;
			end
			// Silence: an invalid measurement keeps the toggle level.
			if (cmd.buzz_off) begin
				buzzer_q <= 1'b0;
				if (last_valid_q) begin
					toggle_q <= 1'b0;
				end
			end
			// Flip the toggle once the interval has elapsed, with wrap-around time.
			if (cmd.buzz_update && (elapsed >= pba_pkg::TIME_W'(interval_q))) begin
				last_toggle_q <= time_q;
				toggle_q      <= ~toggle_q;
				buzzer_q      <= ~toggle_q;
			end
		end
	end

	// Beep interval register.
	always_ff @(posedge clk) begin
		if (cmd.load_fast) begin
			interval_q <= fast_q;
		end else if (cmd.load_interp) begin
			if (slow_ge_fast) begin
				interval_q <= fast_q + div_quot[pba_pkg::PERIOD_W-1:0];
			end else begin
				interval_q <= fast_q - div_quot[pba_pkg::PERIOD_W-1:0];
			end
		end
	end

	// Result register.
	assign alarm = last_valid_q && (last_dist_q < thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.buzzer_on      <= buzzer_q;
			rsp_q.distance       <= last_dist_q;
			rsp_q.distance_valid <= last_valid_q;
			rsp_q.alarm_active   <= alarm;
			rsp_q.measure_done   <= done_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status for the controller.
	assign status.meas_end    = sample_idx_q >= pba_pkg::SIDX_W'(SAMPLES_PER_MEASURE);
	assign status.any_valid   = valid_cnt_q != '0;
	assign status.div_busy    = div_busy;
	assign status.dist_silent = !last_valid_q || (last_dist_q >= thr_q);
	assign status.dist_near   = last_dist_q <= near_q;
	assign status.out_busy    = rsp_valid_q && rsp_stall;

`ifndef SYNTHESIS
	// The sample index never passes the end of a measurement while waiting for an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept_tick || cmd.accept_echo)
			|-> (sample_idx_q < pba_pkg::SIDX_W'(SAMPLES_PER_MEASURE)))
		else $error("sample index beyond the measurement length");

	// No more valid samples than samples taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_cnt_q <= sample_idx_q)
		else $error("valid sample count exceeds sample index");

	// A stalled result item stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled result item changed");
`endif

endmodule

// ----- sv/pba_ctrl.sv -----
// Controller state machine of the proximity beep alarm.
module pba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_cmd,
	output logic              req_stall,
	input  pba_pkg::status_t  status,
	output pba_pkg::cmd_t     cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_ECHO_ACC = 9'b000000010,
		S_CHECK    = 9'b000000100,
		S_AVG_WAIT = 9'b000001000,
		S_BUZZ     = 9'b000010000,
		S_INT_DIV  = 9'b000100000,
		S_INT_WAIT = 9'b001000000,
		S_BUZZ_UPD = 9'b010000000,
		S_FINISH   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// One item at a time: items are taken only in the idle state.
	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && !req_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_cmd == pba_pkg::CMD_TICK) begin
						cmd.accept_tick = 1'b1;
						state_d         = S_FINISH;
					end else begin
						cmd.accept_echo = 1'b1;
						state_d         = S_ECHO_ACC;
					end
				end
			end
			S_ECHO_ACC: begin
				cmd.acc_sample = 1'b1;
				state_d        = S_CHECK;
			end
			S_CHECK: begin
				if (!status.meas_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.end_meas = 1'b1;
					if (status.any_valid) begin
						cmd.div_avg = 1'b1;
						state_d     = S_AVG_WAIT;
					end else begin
						state_d = S_BUZZ;
					end
				end
			end
			S_AVG_WAIT: begin
				if (!status.div_busy) begin
					cmd.store_avg = 1'b1;
					state_d       = S_BUZZ;
				end
			end
			S_BUZZ: begin
				if (status.dist_silent) begin
					cmd.buzz_off = 1'b1;
					state_d      = S_FINISH;
				end else if (status.dist_near) begin
					cmd.load_fast = 1'b1;
					state_d       = S_BUZZ_UPD;
				end else begin
					cmd.mul_interval = 1'b1;
					state_d          = S_INT_DIV;
				end
			end
			S_INT_DIV: begin
				cmd.div_interval = 1'b1;
				state_d          = S_INT_WAIT;
			end
			S_INT_WAIT: begin
				if (!status.div_busy) begin
					cmd.load_interp = 1'b1;
					state_d         = S_BUZZ_UPD;
				end
			end
			S_BUZZ_UPD: begin
				cmd.buzz_update = 1'b1;
				state_d         = S_FINISH;
			end
			S_FINISH: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// A division is never started while the divider is still working.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_avg || cmd.div_interval) |-> !status.div_busy)
		else $error("divider started while busy");

	// A result is never loaded over one that is still held by the receiver.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !status.out_busy)
		else $error("result register overwritten while stalled");

	// After a result is loaded the block is ready for the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> !req_stall)
		else $error("input not reopened after result");
`endif

endmodule

// ----- sv/proximity_beep_alarm.sv -----
// Proximity beep alarm: echo averaging and beep cadence, one item at a time.
//
// Input channel req (req_valid, req_stall, req): each item is either an echo
// length in microseconds or a one-millisecond tick. Output channel rsp
// (rsp_valid, rsp_stall, rsp) returns exactly one result item per input item:
// buzzer level, last averaged distance, its validity, alarm flag and a flag
// telling whether this item completed a measurement.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// six registers; cfg_ready is always high and writes belong to idle periods.
// Sequence: a tick goes from idle straight to the finish state, which loads its
// result; an echo that does not end a measurement first passes through sample
// accumulation and the check. When an echo ends a measurement with a valid
// sample the shared 30-step divider forms the average, and runs again for the
// beep interval when the distance lies between the near distance and the
// threshold. A new item is accepted in the cycle after the previous result is
// registered; a waiting result does not keep the next item out.
// When rsp_stall is high the result register holds its item and the block
// waits with the next result until it is taken. Reset sets every register to
// its default and clears time, toggle, buzzer and the sample accumulator.
module proximity_beep_alarm #(
	parameter int unsigned SAMPLES_PER_MEASURE = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pba_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pba_pkg::rsp_t                    rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pba_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	pba_pkg::cmd_t    cmd;
	pba_pkg::status_t status;

	// Registers can always be written.
	assign cfg_ready = 1'b1;

	// Controller.
	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath.
	pba_datapath #(
		.SAMPLES_PER_MEASURE (SAMPLES_PER_MEASURE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.echo_us   (req.echo_us),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the proximity beep alarm: directed table, then randomised phases.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SAMPLES         = 5;
	localparam int unsigned PLAN_ROWS       = 23;
	localparam int unsigned N_PHASES        = 8;
	localparam int unsigned ITEMS_PER_PHASE = 190;
	localparam int unsigned CALM_PHASE      = 3;
	localparam int unsigned PAUSE_PHASE     = 4;
	localparam int unsigned SPARE_PHASE     = 5;
	localparam int unsigned HOLD_AFTER      = 400;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned DRAIN_CYCLES    = 100;
	localparam int unsigned CYCLE_LIMIT     = 1000000;
	localparam int unsigned SHOWN_FAULTS    = 10;
	localparam int unsigned ECHO_MAX        = 32767;
	localparam int unsigned DIST_REACH      = 9039;

	// Indexes outside the register list; writes to them must change nothing.
	localparam logic [pba_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [pba_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	// Results that can be typed straight into the directed table.
	localparam pba_pkg::rsp_t QUIET      = {1'b0, 13'd0, 1'b0, 1'b0, 1'b0};
	localparam pba_pkg::rsp_t EMPTY_DONE = {1'b0, 13'd0, 1'b0, 1'b0, 1'b1};
	localparam pba_pkg::rsp_t NEAR_DONE  = {1'b0, 13'd50, 1'b1, 1'b1, 1'b1};

	typedef struct packed {
		pba_pkg::req_t item;
		logic          typed;
		pba_pkg::rsp_t want;
	} stim_row_t;

	typedef struct {
		logic [15:0] thr;
		logic [15:0] near;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] slow;
		logic [15:0] fast;
		int unsigned tick_pct;
	} phase_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	pba_pkg::req_t req = '0;
	logic rsp_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [pba_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic req_stall;
	logic rsp_valid;
	logic cfg_ready;
	pba_pkg::rsp_t rsp;

	// Predicted block state and register copies.
	logic [pba_pkg::DIST_W-1:0]   thr_r, near_r, minv_r, maxv_r;
	logic [pba_pkg::PERIOD_W-1:0] slow_r, fast_r;
	logic [31:0]                  now_ms, flip_ms;
	logic                         tone, buzz;
	logic [2:0]                   samp_cnt, n_good;
	logic [15:0]                  acc_sum;
	logic [pba_pkg::DIST_W-1:0]   avg_dist;
	logic                         avg_ok;

	pba_pkg::rsp_t pending_rsp[$];
	int unsigned faults       = 0;
	int unsigned results_seen = 0;
	int unsigned hold_left    = 0;
	logic        hold_done    = 1'b0;
	logic        calm         = 1'b0;
	int unsigned cycles       = 0;
	int unsigned aim          = 0;

	proximity_beep_alarm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Beep interval for a distance below the threshold, interpolated between the rates.
	function automatic logic [31:0] cadence_ms(input logic [pba_pkg::DIST_W-1:0] d);
		logic [63:0] num;
		logic [63:0] den;
		if (d >= thr_r)
			return {16'd0, slow_r};
		if (d <= near_r)
			return {16'd0, fast_r};
		den = 64'(thr_r - near_r);
		if (slow_r >= fast_r) begin
			num = 64'(d - near_r) * 64'(slow_r - fast_r);
			return 32'(64'(fast_r) + num / den);
		end
		// Slow rate below fast rate: the step is rounded towards the slow side.
		num = 64'(d - near_r) * 64'(fast_r - slow_r);
		return 32'(64'(fast_r) - (num + den - 64'd1) / den);
	endfunction

	// Advances the predicted state by one item and returns the result it gives.
	function automatic pba_pkg::rsp_t beep_predict(input pba_pkg::req_t r);
		logic [31:0]   wide;
		logic [13:0]   d;
		logic          done;
		pba_pkg::rsp_t o;
		done = 1'b0;
		if (r.cmd == pba_pkg::CMD_TICK) begin
			now_ms = now_ms + 32'd1;
		end else begin
			// A timed-out echo still counts as a sample.
			if (r.echo_us != 0) begin
				wide = 32'(r.echo_us);
				wide = wide * 16 / 58;
				d = wide[13:0];
				if (d >= minv_r && d <= maxv_r) begin
					acc_sum = acc_sum + 16'(d);
					n_good = n_good + 3'd1;
				end
			end
			samp_cnt = samp_cnt + 3'd1;
			if (samp_cnt >= SAMPLES) begin
				if (n_good != 0) begin
					wide = 32'(acc_sum / 16'(n_good));
					avg_dist = wide[pba_pkg::DIST_W-1:0];
					avg_ok = 1'b1;
				end else begin
					avg_dist = '0;
					avg_ok = 1'b0;
				end
				samp_cnt = '0;
				acc_sum = '0;
				n_good = '0;
				done = 1'b1;
				// Buzzer update: silence when invalid, clear at or beyond the threshold.
				if (!avg_ok) begin
					buzz = 1'b0;
				end else if (avg_dist >= thr_r) begin
					buzz = 1'b0;
					tone = 1'b0;
				end else if (now_ms - flip_ms >= cadence_ms(avg_dist)) begin
					flip_ms = now_ms;
					tone = ~tone;
					buzz = tone;
				end
			end
		end
		o.buzzer_on = buzz;
		o.distance = avg_dist;
		o.distance_valid = avg_ok;
		o.alarm_active = avg_ok && (avg_dist < thr_r);
		o.measure_done = done;
		return o;
	endfunction

	function automatic void beep_reset();
		thr_r = pba_pkg::THRESHOLD_RST;
		near_r = pba_pkg::NEAR_RST;
		minv_r = pba_pkg::MIN_VALID_RST;
		maxv_r = pba_pkg::MAX_VALID_RST;
		slow_r = pba_pkg::SLOW_RST;
		fast_r = pba_pkg::FAST_RST;
		now_ms = '0;
		flip_ms = '0;
		tone = 1'b0;
		buzz = 1'b0;
		samp_cnt = '0;
		n_good = '0;
		acc_sum = '0;
		avg_dist = '0;
		avg_ok = 1'b0;
	endfunction

	// Directed stimulus: reset state, field extremes, validity limits and each distance band.
	function automatic stim_row_t plan_row(input int unsigned i);
		case (i)
		0:  return {pba_pkg::CMD_TICK, 15'd0,     1'b1, QUIET};
		1:  return {pba_pkg::CMD_TICK, 15'd32767, 1'b1, QUIET};
		2:  return {pba_pkg::CMD_ECHO, 15'd0,     1'b1, QUIET};
		3:  return {pba_pkg::CMD_ECHO, 15'd32767, 1'b1, QUIET};
		4:  return {pba_pkg::CMD_ECHO, 15'd1,     1'b1, QUIET};
		5:  return {pba_pkg::CMD_ECHO, 15'd0,     1'b1, QUIET};
		6:  return {pba_pkg::CMD_ECHO, 15'd0,     1'b1, EMPTY_DONE};
		7, 8, 9, 10:
			return {pba_pkg::CMD_ECHO, 15'd182,   1'b0, QUIET};
		11: return {pba_pkg::CMD_ECHO, 15'd182,   1'b1, NEAR_DONE};
		12: return {pba_pkg::CMD_ECHO, 15'd116,   1'b0, QUIET};
		13: return {pba_pkg::CMD_ECHO, 15'd115,   1'b0, QUIET};
		14: return {pba_pkg::CMD_ECHO, 15'd23200, 1'b0, QUIET};
		15: return {pba_pkg::CMD_ECHO, 15'd23204, 1'b0, QUIET};
		16: return {pba_pkg::CMD_ECHO, 15'd0,     1'b0, QUIET};
		17: return {pba_pkg::CMD_TICK, 15'd0,     1'b0, QUIET};
		default:
			return {pba_pkg::CMD_ECHO, 15'd725,   1'b0, QUIET};
		endcase
	endfunction

	// Register settings of each random phase, the extremes among them.
	function automatic phase_t phase_cfg(input int unsigned p);
		phase_t s;
		case (p)
		0:  s = '{16'd320,  16'd80,   16'd32,   16'd6400, 16'd20,    16'd3,     55};
		1:  s = '{16'd8191, 16'd0,    16'd0,    16'd8191, 16'd0,     16'd65535, 50};
		2:  s = '{16'd0,    16'd8191, 16'd8191, 16'd0,    16'd65535, 16'd1,     40};
		3:  s = '{16'd1000, 16'd1000, 16'd100,  16'd2000, 16'd5,     16'd0,     45};
		4:  s = '{16'd2000, 16'd500,  16'd50,   16'd3000, 16'd1,     16'd30,    60};
		5:  s = '{16'd6400, 16'd0,    16'd0,    16'd6400, 16'd65535, 16'd65535, 50};
		6:  s = '{16'd3000, 16'd2999, 16'd0,    16'd8191, 16'd40,    16'd2,     65};
		default:
			s = '{16'd500,  16'd100,  16'd0,    16'd8191, 16'd12,    16'd12,    50};
		endcase
		return s;
	endfunction

	// Random item: a tick or an echo; echoes are mostly aimed around the alarm band, some timeouts and wild echoes.
	function automatic pba_pkg::req_t random_item(input int unsigned tick_pct);
		pba_pkg::req_t r;
		int unsigned   roll;
		int unsigned   e;
		int unsigned   hi;
		r.cmd = pba_pkg::CMD_ECHO;
		r.echo_us = 15'($urandom);
		if ($urandom_range(99) < tick_pct) begin
			r.cmd = pba_pkg::CMD_TICK;
			return r;
		end
		roll = $urandom_range(99);
		if (roll < 10) begin
			r.echo_us = '0;
		end else if (roll < 25) begin
			r.echo_us = 15'($urandom_range(ECHO_MAX));
		end else begin
			// A fresh aim for every measurement keeps the five samples close together.
			if (samp_cnt == 0) begin
				hi = thr_r + thr_r / 2 + 64;
				if (hi > DIST_REACH)
					hi = DIST_REACH;
				aim = $urandom_range(hi);
			end
			e = aim * 58 / 16 + $urandom_range(3);
			if (e > ECHO_MAX)
				e = ECHO_MAX;
			r.echo_us = 15'(e);
		end
		return r;
	endfunction

	function automatic logic [15:0] with_junk(input logic [15:0] v);
		logic [2:0] top;
		top = 3'($urandom_range(7));
		return {top, v[12:0]};
	endfunction

	function automatic void log_fault(input string msg);
		faults++;
		if (faults <= SHOWN_FAULTS)
			$display("%s", msg);
	endfunction

	// Offers one item, with random idle cycles first, and records its expected result.
	task automatic send_item(input pba_pkg::req_t r, input logic typed,
		input pba_pkg::rsp_t want);
		pba_pkg::rsp_t guess;
		while (!calm && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		guess = beep_predict(r);
		pending_rsp.push_back(typed ? want : guess);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller lowers the write valid after its last write.
	task automatic write_reg(input logic [pba_pkg::CFG_INDEX_W-1:0] idx,
		input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		pba_pkg::REG_ALARM_THRESHOLD: thr_r = val[pba_pkg::DIST_W-1:0];
		pba_pkg::REG_NEAR_DISTANCE:   near_r = val[pba_pkg::DIST_W-1:0];
		pba_pkg::REG_MIN_VALID:       minv_r = val[pba_pkg::DIST_W-1:0];
		pba_pkg::REG_MAX_VALID:       maxv_r = val[pba_pkg::DIST_W-1:0];
		pba_pkg::REG_SLOW_PERIOD:     slow_r = val;
		pba_pkg::REG_FAST_PERIOD:     fast_r = val;
		default: ;
		endcase
	endtask

	// Result checking and output stall, with one long hold-off once traffic is flowing.
	always @(posedge clk) begin
		pba_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen <= results_seen + 1;
			if (pending_rsp.size() == 0) begin
				log_fault($sformatf("unexpected item: buzz=%0d dist=%0d valid=%0d alarm=%0d done=%0d",
					rsp.buzzer_on, rsp.distance, rsp.distance_valid, rsp.alarm_active,
					rsp.measure_done));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.buzzer_on !== want.buzzer_on || rsp.distance !== want.distance ||
					rsp.distance_valid !== want.distance_valid ||
					rsp.alarm_active !== want.alarm_active ||
					rsp.measure_done !== want.measure_done) begin
					log_fault($sformatf({"mismatch: expected buzz=%0d dist=%0d valid=%0d alarm=%0d ",
						"done=%0d, got buzz=%0d dist=%0d valid=%0d alarm=%0d done=%0d"},
						want.buzzer_on, want.distance, want.distance_valid, want.alarm_active,
						want.measure_done, rsp.buzzer_on, rsp.distance, rsp.distance_valid,
						rsp.alarm_active, rsp.measure_done));
				end
			end
		end
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !calm && ($urandom_range(99) < 23);
		end
	end

	// Main sequence: reset, directed table, then the random phases.
	initial begin
		stim_row_t row;
		phase_t    set;
		beep_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < PLAN_ROWS; i++) begin
			row = plan_row(i);
			send_item(row.item, row.typed, row.want);
		end

		for (int unsigned p = 0; p < N_PHASES; p++) begin
			set = phase_cfg(p);
			settle();
			calm = (p == CALM_PHASE);
			write_reg(pba_pkg::REG_ALARM_THRESHOLD, with_junk(set.thr));
			write_reg(pba_pkg::REG_NEAR_DISTANCE, with_junk(set.near));
			write_reg(pba_pkg::REG_MIN_VALID, with_junk(set.lo));
			write_reg(pba_pkg::REG_MAX_VALID, with_junk(set.hi));
			write_reg(pba_pkg::REG_SLOW_PERIOD, set.slow);
			write_reg(pba_pkg::REG_FAST_PERIOD, set.fast);
			if (p == SPARE_PHASE) begin
				write_reg(REG_SPARE_LO, 16'($urandom));
				write_reg(REG_SPARE_HI, 16'($urandom));
			end
			cfg_valid <= 1'b0;
			for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Once, the sender waits for the block to empty completely.
				if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2)
					settle();
				send_item(random_item(set.tick_pct), 1'b0, QUIET);
			end
		end

		settle();
		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0)
			log_fault("expected items never arrived");
		if (faults == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pba_pkg.sv
sv/pba_div.sv
sv/pba_datapath.sv
sv/pba_ctrl.sv
sv/proximity_beep_alarm.sv
tb/tb_top.sv
